[rtl/core/glcm_pkg.sv]
// ----------------------------------------------------------------------------
// glcm_pkg
// shared constants of the gray-level co-occurrence histogram
// ----------------------------------------------------------------------------
package glcm_pkg;

  // payload widths
  localparam int LEVEL_W  = 8;
  localparam int COUNT_W  = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int OFS_X_W    = 10;
  localparam int OFS_Y_W    = 3;
  localparam int DIM_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;

  localparam logic [OFS_X_W-1:0] OFFSET_X_RST     = 10'd1;
  localparam logic [OFS_Y_W-1:0] OFFSET_Y_RST     = 3'd0;
  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 11'd256;
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 11'd256;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

endpackage

[rtl/core/glcm_ram.sv]
// ----------------------------------------------------------------------------
// glcm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module glcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns old data on a same-address write; data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gray_level_cooccurrence_histogram.sv]
// ----------------------------------------------------------------------------
// gray_level_cooccurrence_histogram
// co-occurrence histogram of a raster pixel stream with read-and-clear access
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries commands. cmd 0 is a pixel
// in raster order; image_start_i marks row 0, column 0. The pixel at
// (r, c) pairs with the earlier pixel at (r - offset_y, c - offset_x) and the
// entry (earlier level, current level) counts up, saturating at 2^21-1.
// cmd 1 reads one entry, returns it on the output channel and clears it.
// Output channel (out_valid_o / out_ready_i) holds one result register, so a
// new command is taken while a result waits; a read that finds the register
// still full waits in the histogram stage until it drains.
// A pixel with no partner is taken in the idle state alone; a counted pixel
// goes through delay store read, histogram read and histogram write back; a
// read issues its histogram read and then waits only on a stalled output. The
// histogram read-modify-write on the single ram holds off the next command.
// After reset all LEVELS*LEVELS entries (65536 by default) of the histogram
// are swept to zero, one entry per cycle; in_ready_o stays low meanwhile.
// Configuration writes are taken at any time, one per cycle, and are meant to
// happen only while the block is idle.
// ----------------------------------------------------------------------------
module gray_level_cooccurrence_histogram #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int LEVELS         = 256,
  parameter int MAX_ROW_OFFSET = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [glcm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [glcm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // command input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [glcm_pkg::LEVEL_W-1:0]       pixel_level_i,
  input  logic                               image_start_i,
  input  logic [glcm_pkg::LEVEL_W-1:0]       read_first_level_i,
  input  logic [glcm_pkg::LEVEL_W-1:0]       read_second_level_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [glcm_pkg::COUNT_W-1:0]       pair_count_o,
  output logic                               count_saturated_o
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;
  localparam int SLOT_W     = (MAX_ROW_OFFSET > 1) ? $clog2(MAX_ROW_OFFSET) : 1;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int DLY_DEPTH  = MAX_ROW_OFFSET * MAX_WIDTH;
  localparam int DA_W       = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
  localparam int HIST_DEPTH = LEVELS * LEVELS;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int CW         = glcm_pkg::COUNT_W;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_DLY,
    ST_HST
  } state_e;

  // control state
  state_e                    state_q, state_d;
  logic [HA_W-1:0]           clr_q, clr_d;
  logic                      out_valid_q, out_valid_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      sat_q, sat_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [SLOT_W-1:0]         slot_q, slot_d;

  // configuration registers
  logic [glcm_pkg::OFS_X_W-1:0] offset_x_q;
  logic [glcm_pkg::OFS_Y_W-1:0] offset_y_q;
  logic [glcm_pkg::DIM_W-1:0]   image_width_q;
  logic [glcm_pkg::DIM_W-1:0]   image_height_q;

  // per-command payload
  logic                      cmd_q;
  logic [LVL_W-1:0]          lvl_q;
  logic                      self_q;
  logic                      rd_ok_q;
  logic [HA_W-1:0]           haddr_q;

  // handshake
  logic                      in_go;
  logic                      pix_go;

  // raster position step
  logic [WID_W-1:0]          w_eff;
  logic [ROW_W-1:0]          h_eff;
  logic [COL_W-1:0]          c0, c1, fcol;
  logic [ROW_W-1:0]          r0, r1;
  logic [SLOT_W-1:0]         s0, s1, fslot;
  logic [SLOT_W:0]           fslot_w, oy_s;
  logic [WID_W-1:0]          c_next;
  logic                      live, pair;
  logic [LVL_W-1:0]          lvl;

  // memory ports
  logic                      dly_we, dly_re;
  logic [DA_W-1:0]           dly_waddr, dly_raddr;
  logic [LVL_W-1:0]          dly_rdata;
  logic                      hist_we, hist_re;
  logic [HA_W-1:0]           hist_waddr, hist_raddr;
  logic [CW-1:0]             hist_wdata, hist_rdata, hist_inc;
  logic [LVL_W-1:0]          first_lvl;
  logic                      rd_ok;
  logic [HA_W-1:0]           rd_addr, pix_addr;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(MAX_ROW_OFFSET - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_go      = in_valid_i && in_ready_o;
  assign pix_go     = in_go && (cmd_i == glcm_pkg::CMD_PIXEL);

  // effective image size
  always_comb begin
    if (image_width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(image_width_q);
    end
    if (image_height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(image_height_q);
    end
  end

  // position of the incoming pixel and its partner
  always_comb begin
    c0 = image_start_i ? '0 : col_q;
    r0 = image_start_i ? '0 : row_q;
    s0 = image_start_i ? '0 : slot_q;
    c1 = c0;
    r1 = r0;
    s1 = s0;
    // width shrank below the column: move to the next row first
    if (WID_W'(c0) >= w_eff) begin
      c1 = '0;
      if (r0 < h_eff) begin
        r1 = r0 + ROW_W'(1);
        s1 = slot_inc(s0);
      end
    end
    live = (r1 < h_eff);
    if (32'(pixel_level_i) >= LEVELS) begin
      lvl = LVL_W'(LEVELS - 1);
    end else begin
      lvl = LVL_W'(pixel_level_i);
    end
    pair = live && (32'(offset_y_q) < MAX_ROW_OFFSET)
         && (32'(r1) >= 32'(offset_y_q)) && (32'(c1) >= 32'(offset_x_q));
    oy_s    = (SLOT_W + 1)'(offset_y_q);
    fslot_w = {1'b0, s1} - oy_s;
    if ({1'b0, s1} < oy_s) begin
      fslot_w = fslot_w + (SLOT_W + 1)'(MAX_ROW_OFFSET);
    end
    fslot = fslot_w[SLOT_W-1:0];
    fcol  = c1 - COL_W'(offset_x_q);

    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    c_next = WID_W'(c1) + WID_W'(1);
    if (pix_go) begin
      col_d  = c1;
      row_d  = r1;
      slot_d = s1;
      if (live) begin
        if (c_next >= w_eff) begin
          col_d  = '0;
          row_d  = r1 + ROW_W'(1);
          slot_d = slot_inc(s1);
        end else begin
          col_d = COL_W'(c_next);
        end
      end
    end
  end

  assign dly_we    = pix_go && live;
  assign dly_waddr = DA_W'(s1) * DA_W'(MAX_WIDTH) + DA_W'(c1);
  assign dly_re    = pix_go && pair;
  assign dly_raddr = DA_W'(fslot) * DA_W'(MAX_WIDTH) + DA_W'(fcol);

  glcm_ram #(
    .WIDTH (LVL_W),
    .DEPTH (DLY_DEPTH)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (lvl),
    .re_i    (dly_re),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  // histogram addressing
  assign rd_ok = (32'(read_first_level_i) < LEVELS) && (32'(read_second_level_i) < LEVELS);
  assign rd_addr = HA_W'(LVL_W'(read_first_level_i)) * HA_W'(LEVELS)
                 + HA_W'(LVL_W'(read_second_level_i));
  // with both offsets zero the partner is the pixel just written
  assign first_lvl = self_q ? lvl_q : dly_rdata;
  assign pix_addr  = HA_W'(first_lvl) * HA_W'(LEVELS) + HA_W'(lvl_q);
  assign hist_inc  = (hist_rdata == glcm_pkg::COUNT_MAX) ? glcm_pkg::COUNT_MAX
                                                         : hist_rdata + CW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    count_d     = count_q;
    sat_d       = sat_q;
    hist_we     = 1'b0;
    hist_waddr  = haddr_q;
    hist_wdata  = '0;
    hist_re     = 1'b0;
    hist_raddr  = pix_addr;
    case (state_q)
      ST_CLR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        clr_d      = clr_q + HA_W'(1);
        if (clr_q == HA_W'(HIST_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_go) begin
          if (cmd_i == glcm_pkg::CMD_READ) begin
            hist_re    = 1'b1;
            hist_raddr = rd_addr;
            state_d    = ST_HST;
          end else if (pair) begin
            state_d = ST_DLY;
          end
        end
      end
      ST_DLY: begin
        hist_re = 1'b1;
        state_d = ST_HST;
      end
      ST_HST: begin
        if (cmd_q == glcm_pkg::CMD_PIXEL) begin
          hist_we    = 1'b1;
          hist_wdata = hist_inc;
          state_d    = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          count_d     = rd_ok_q ? hist_rdata : '0;
          sat_d       = rd_ok_q && (hist_rdata == glcm_pkg::COUNT_MAX);
          hist_we     = rd_ok_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  glcm_ram #(
    .WIDTH (CW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLR;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
      count_q        <= '0;
      sat_q          <= 1'b0;
      col_q          <= '0;
      row_q          <= '0;
      slot_q         <= '0;
      offset_x_q     <= glcm_pkg::OFFSET_X_RST;
      offset_y_q     <= glcm_pkg::OFFSET_Y_RST;
      image_width_q  <= glcm_pkg::IMAGE_WIDTH_RST;
      image_height_q <= glcm_pkg::IMAGE_HEIGHT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      sat_q       <= sat_d;
      col_q       <= col_d;
      row_q       <= row_d;
      slot_q      <= slot_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          glcm_pkg::CFG_OFFSET_X:     offset_x_q     <= cfg_wdata_i[glcm_pkg::OFS_X_W-1:0];
          glcm_pkg::CFG_OFFSET_Y:     offset_y_q     <= cfg_wdata_i[glcm_pkg::OFS_Y_W-1:0];
          glcm_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[glcm_pkg::DIM_W-1:0];
          glcm_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[glcm_pkg::DIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      cmd_q   <= cmd_i;
      rd_ok_q <= rd_ok;
    end
    if (pix_go) begin
      lvl_q  <= lvl;
      self_q <= (offset_x_q == '0) && (offset_y_q == '0);
    end
    if (hist_re) begin
      haddr_q <= hist_raddr;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pair_count_o      = count_q;
  assign count_saturated_o = sat_q;

  // a result only appears after a read command passed the histogram stage
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_HST) && $past(cmd_q == glcm_pkg::CMD_READ))
    else $error("result without a read command");

  // read and write of the histogram never fall in the same cycle
  a_hist_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_re |-> !hist_we)
    else $error("histogram read overlaps write back");

  // the saturation flag agrees with the count it goes with
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sat_q == (count_q == glcm_pkg::COUNT_MAX)))
    else $error("saturation flag mismatch");

  // no result is pending while the histogram is being swept
  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !out_valid_q && !hist_re)
    else $error("activity during clearing sweep");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gray-level co-occurrence histogram
// ----------------------------------------------------------------------------
// Pixel and read commands go in through a queue-fed driver. A behavioral copy
// of the histogram, the row delay buffer and the raster position predicts
// every read-and-clear count. A monitor checks each count and saturation flag
// in order. Both handshake sides idle at random. Directed cases cover reset
// offsets, zero offsets, clamped sizes, a width that shrinks mid-image and
// ignored register indexes. Random images follow, with small sizes and a small
// palette of levels so that entries build up counts before they are read.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_W       = 1024;
  localparam int unsigned MAX_H       = 1024;
  localparam int unsigned LEVELS      = 256;
  localparam int unsigned ROW_OFS     = 8;
  localparam int unsigned RANDOM_CMDS = 1750;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam logic [glcm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST =
    glcm_pkg::CFG_IMAGE_HEIGHT + 1'b1;
  localparam logic [glcm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic                         cmd;
    logic [glcm_pkg::LEVEL_W-1:0] level;
    logic                         start;
    logic [glcm_pkg::LEVEL_W-1:0] first_lvl;
    logic [glcm_pkg::LEVEL_W-1:0] second_lvl;
  } glcm_cmd_t;

  typedef struct packed {
    logic [glcm_pkg::COUNT_W-1:0] count;
    logic                         saturated;
  } pair_count_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [glcm_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [glcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic                            cmd_i = glcm_pkg::CMD_PIXEL;
  logic [glcm_pkg::LEVEL_W-1:0]    pixel_level_i = '0;
  logic                            image_start_i = 1'b0;
  logic [glcm_pkg::LEVEL_W-1:0]    read_first_level_i = '0;
  logic [glcm_pkg::LEVEL_W-1:0]    read_second_level_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [glcm_pkg::COUNT_W-1:0]    pair_count_o;
  logic                            count_saturated_o;

  gray_level_cooccurrence_histogram uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cmd_i               (cmd_i),
    .pixel_level_i       (pixel_level_i),
    .image_start_i       (image_start_i),
    .read_first_level_i  (read_first_level_i),
    .read_second_level_i (read_second_level_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pair_count_o        (pair_count_o),
    .count_saturated_o   (count_saturated_o)
  );

  always #1 clk_i = ~clk_i;

  // expected histogram state
  logic [glcm_pkg::COUNT_W-1:0]  pair_hist [LEVELS*LEVELS];
  logic [glcm_pkg::LEVEL_W-1:0]  row_buf [ROW_OFS*MAX_W];
  int unsigned                   col_pos, row_pos;
  logic [glcm_pkg::OFS_X_W-1:0]  ofs_x = glcm_pkg::OFFSET_X_RST;
  logic [glcm_pkg::OFS_Y_W-1:0]  ofs_y = glcm_pkg::OFFSET_Y_RST;
  logic [glcm_pkg::DIM_W-1:0]    img_w = glcm_pkg::IMAGE_WIDTH_RST;
  logic [glcm_pkg::DIM_W-1:0]    img_h = glcm_pkg::IMAGE_HEIGHT_RST;

  glcm_cmd_t   pending_cmds [$];
  pair_count_t expected_counts [$];
  glcm_cmd_t   cur_cmd;
  pair_count_t exp_count;
  logic [glcm_pkg::LEVEL_W-1:0] pal [3];

  int unsigned n_queued, n_pixels, n_reads, n_checked, n_fail, n_configs, n_cycles;
  int unsigned send_gap, send_calm, recv_gap, recv_calm, hold_left;
  int unsigned holds_requested, holds_served;

  function automatic int unsigned clamp_dim(input logic [glcm_pkg::DIM_W-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // cycles to wait before the next transfer; now and then a run with no gaps
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(16, 64);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [glcm_pkg::LEVEL_W-1:0] pick_level();
    if ($urandom_range(0, 6) == 0) return glcm_pkg::LEVEL_W'($urandom);
    return pal[$urandom_range(0, 2)];
  endfunction

  task automatic accumulate_pair_counts(input glcm_cmd_t c);
    int unsigned w, h, r, k, first, idx;
    if (c.cmd == glcm_pkg::CMD_PIXEL) begin
      n_pixels++;
      w = clamp_dim(img_w, MAX_W);
      h = clamp_dim(img_h, MAX_H);
      if (c.start) begin
        row_pos = 0;
        col_pos = 0;
      end
      // width shrank under the current column
      if (col_pos >= w) begin
        col_pos = 0;
        if (row_pos < h) row_pos++;
      end
      if (row_pos < h) begin
        r = row_pos;
        k = col_pos;
        row_buf[(r % ROW_OFS) * MAX_W + k] = c.level;
        if (ofs_y < ROW_OFS && r >= ofs_y && k >= ofs_x) begin
          first = row_buf[((r - ofs_y) % ROW_OFS) * MAX_W + k - ofs_x];
          idx = first * LEVELS + c.level;
          if (pair_hist[idx] != glcm_pkg::COUNT_MAX) pair_hist[idx] = pair_hist[idx] + 1'b1;
        end
        col_pos = k + 1;
        if (col_pos >= w) begin
          col_pos = 0;
          if (row_pos < h) row_pos++;
        end
      end
    end else begin
      n_reads++;
      idx = c.first_lvl * LEVELS + c.second_lvl;
      expected_counts.push_back('{count: pair_hist[idx],
                                  saturated: pair_hist[idx] == glcm_pkg::COUNT_MAX});
      pair_hist[idx] = '0;
    end
  endtask

  // driver: one transfer per accepted command, random gap before the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accumulate_pair_counts(cur_cmd);
        send_gap = draw_wait(send_calm);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_valid_i          <= 1'b1;
          cmd_i               <= cur_cmd.cmd;
          pixel_level_i       <= cur_cmd.level;
          image_start_i       <= cur_cmd.start;
          read_first_level_i  <= cur_cmd.first_lvl;
          read_second_level_i <= cur_cmd.second_lvl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each count transfer, stall the output side at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          $error("unexpected result: pair_count %0d count_saturated %0b",
                 pair_count_o, count_saturated_o);
          n_fail++;
        end else begin
          exp_count = expected_counts.pop_front();
          if (pair_count_o !== exp_count.count) begin
            $error("pair_count: expected %0d, got %0d", exp_count.count, pair_count_o);
            n_fail++;
          end
          if (count_saturated_o !== exp_count.saturated) begin
            $error("count_saturated: expected %0b, got %0b",
                   exp_count.saturated, count_saturated_o);
            n_fail++;
          end
        end
        n_checked++;
        recv_gap = draw_wait(recv_calm);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts still due",
               n_cycles, expected_counts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_pixel(input logic [glcm_pkg::LEVEL_W-1:0] lvl, input logic start);
    glcm_cmd_t c;
    c.cmd        = glcm_pkg::CMD_PIXEL;
    c.level      = lvl;
    c.start      = start;
    c.first_lvl  = glcm_pkg::LEVEL_W'($urandom);
    c.second_lvl = glcm_pkg::LEVEL_W'($urandom);
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic push_read(input logic [glcm_pkg::LEVEL_W-1:0] a,
                           input logic [glcm_pkg::LEVEL_W-1:0] b);
    glcm_cmd_t c;
    c.cmd        = glcm_pkg::CMD_READ;
    c.level      = glcm_pkg::LEVEL_W'($urandom);
    c.start      = 1'($urandom);
    c.first_lvl  = a;
    c.second_lvl = b;
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic write_reg(input logic [glcm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data[glcm_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      glcm_pkg::CFG_OFFSET_X:     ofs_x = data[glcm_pkg::OFS_X_W-1:0];
      glcm_pkg::CFG_OFFSET_Y:     ofs_y = data[glcm_pkg::OFS_Y_W-1:0];
      glcm_pkg::CFG_IMAGE_WIDTH:  img_w = data[glcm_pkg::DIM_W-1:0];
      glcm_pkg::CFG_IMAGE_HEIGHT: img_h = data[glcm_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  // all commands sent, all counts back, then let a pixel update finish
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_counts.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ox, oy, wv, hv, eff_w, eff_h, n_pix, n_img, phase_no, start_cnt;
    for (int i = 0; i < LEVELS * LEVELS; i++) pair_hist[i] = '0;
    for (int i = 0; i < ROW_OFS * MAX_W; i++) row_buf[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset offsets: horizontal neighbors, back-to-back read clears the entry
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hAA, 1'b0);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'h55, 1'b0);
    push_read(8'h00, 8'hFF);
    push_read(8'h00, 8'hFF);
    push_read(8'hFF, 8'hFF);
    push_read(8'h55, 8'h55);
    wait_idle();

    // zero offsets pair a pixel with itself; zero sizes act as a 1x1 image
    write_reg(glcm_pkg::CFG_OFFSET_X, 0);
    write_reg(glcm_pkg::CFG_OFFSET_Y, 0);
    write_reg(glcm_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(glcm_pkg::CFG_IMAGE_HEIGHT, 0);
    write_reg(CFG_UNUSED_FIRST, 2047);
    write_reg(CFG_UNUSED_LAST, 0);
    n_configs++;
    push_pixel(8'h07, 1'b1);
    push_pixel(8'h09, 1'b0);
    push_read(8'h07, 8'h07);
    push_read(8'h09, 8'h09);
    wait_idle();

    // largest settings: sizes clamp, no partner within reach
    write_reg(glcm_pkg::CFG_OFFSET_X, 1023);
    write_reg(glcm_pkg::CFG_OFFSET_Y, 7);
    write_reg(glcm_pkg::CFG_IMAGE_WIDTH, 2047);
    write_reg(glcm_pkg::CFG_IMAGE_HEIGHT, 2047);
    n_configs++;
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_read(8'hFF, 8'hFF);
    wait_idle();

    // width shrinks mid-image, the column in flight wraps to the next row
    write_reg(glcm_pkg::CFG_OFFSET_X, 0);
    write_reg(glcm_pkg::CFG_OFFSET_Y, 1);
    write_reg(glcm_pkg::CFG_IMAGE_WIDTH, 4);
    write_reg(glcm_pkg::CFG_IMAGE_HEIGHT, 8);
    n_configs++;
    push_pixel(8'd10, 1'b1);
    push_pixel(8'd11, 1'b0);
    push_pixel(8'd12, 1'b0);
    push_pixel(8'd13, 1'b0);
    push_pixel(8'd20, 1'b0);
    push_pixel(8'd21, 1'b0);
    wait_idle();
    write_reg(glcm_pkg::CFG_IMAGE_WIDTH, 2);
    push_pixel(8'd30, 1'b0);
    push_pixel(8'd31, 1'b0);
    push_pixel(8'd40, 1'b0);
    push_read(8'd10, 8'd20);
    push_read(8'd20, 8'd30);
    push_read(8'd30, 8'd40);

    start_cnt = n_queued;
    phase_no = 0;
    while (n_queued - start_cnt < RANDOM_CMDS) begin
      wait_idle();
      phase_no++;
      n_configs++;
      case ($urandom_range(0, 9))
        0:       wv = 0;
        1:       wv = $urandom_range(13, 2047);
        default: wv = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       hv = 0;
        1:       hv = $urandom_range(11, 2047);
        default: hv = $urandom_range(1, 10);
      endcase
      eff_w = clamp_dim(glcm_pkg::DIM_W'(wv), MAX_W);
      eff_h = clamp_dim(glcm_pkg::DIM_W'(hv), MAX_H);
      case ($urandom_range(0, 9))
        0:       ox = $urandom_range(0, 1023);
        1, 2:    ox = $urandom_range(0, eff_w - 1);
        default: ox = $urandom_range(0, 2);
      endcase
      oy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      write_reg(glcm_pkg::CFG_OFFSET_X, ox);
      write_reg(glcm_pkg::CFG_OFFSET_Y, oy);
      write_reg(glcm_pkg::CFG_IMAGE_WIDTH, wv);
      write_reg(glcm_pkg::CFG_IMAGE_HEIGHT, hv);
      if ($urandom_range(0, 3) == 0)
        write_reg(glcm_pkg::CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                  $urandom);
      for (int i = 0; i < 3; i++)
        pal[i] = ($urandom_range(0, 4) == 0) ? {glcm_pkg::LEVEL_W{1'($urandom)}}
                                             : glcm_pkg::LEVEL_W'($urandom);

      // output held off while reads pile up behind the result register
      if (phase_no == 2) begin
        holds_requested++;
        for (int i = 0; i < 4; i++) push_read(pick_level(), pick_level());
      end

      n_img = $urandom_range(1, 2);
      for (int im = 0; im < n_img; im++) begin
        n_pix = eff_w * eff_h + $urandom_range(0, 3);
        if (n_pix > 150) n_pix = $urandom_range(20, 150);
        for (int p = 0; p < n_pix; p++) begin
          // a stray image start now and then breaks the raster
          push_pixel(pick_level(), p == 0 || $urandom_range(0, 39) == 0);
          if ($urandom_range(0, 4) == 0) push_read(pick_level(), pick_level());
        end
      end
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) push_read(pal[a], pal[b]);
    end
    wait_idle();

    $display("%0d commands sent: %0d pixels, %0d histogram reads, %0d settings",
             n_queued, n_pixels, n_reads, n_configs);
    $display("%0d counts checked, %0d field mismatches", n_checked, n_fail);
    if (n_fail == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
